// File: rtl/core/ptrr_pkg.sv
// Shared types and constants for the pulse timing record/replay block.
// No dependencies; every module of the block but ptrr_store imports this package.
package ptrr_pkg;

    // Operation codes carried in s_tuser
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_REC  = 2'd1;
    localparam logic [1:0] OP_PLAY = 2'd2;

    // Run modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_REC  = 2'd1;
    localparam logic [1:0] MODE_PLAY = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_WINDOW_START  = 2'd0;
    localparam logic [1:0] REG_WINDOW_LENGTH = 2'd1;
    localparam logic [1:0] REG_REPEAT_COUNT  = 2'd2;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int WIN_START_W  = 8;
    localparam int WIN_LENGTH_W = 9;
    localparam int REPEAT_W     = 16;
    localparam int STORED_W     = 9;

    typedef struct packed {
        logic [STORED_W-1:0] entries_stored;
        logic                playing;
        logic                recording;
        logic                drive_level;
    } ptrr_result_t;

endpackage

// File: rtl/core/pulse_timing_record_replay_top.sv
// Top level of the pulse timing record/replay block.
// Depends on ptrr_pkg, ptrr_store, ptrr_ctrl and ptrr_out_buf.
//
// Usage:
//   Slave channel: one transaction per sampled tick. s_tuser carries the op
//   (tick, start recording, start playback); s_tdata[0] is the raw active-low
//   pin sample. Every transaction yields exactly one result transaction.
//   Master channel: m_tdata carries drive level, recording and playing flags
//   and the number of entries written by the latest recording.
//   Configuration: cfg_we writes cfg_wdata to the register at cfg_index
//   (window start, window length, repeat count); write only while idle.
// Output: a result is registered in the output buffer's head stage, or held in
//   its skid stage while the receiver stalls. Throughput: one transaction per
//   cycle while s_tready is high; store reads are registered ahead from the
//   next state, with the next playback entry prefetched on port A and the first
//   window entry on port B, so an entry change never stalls.
// Reset: control state and registers return to their defaults; store contents
//   are kept and hold undefined data until recorded. No clearing pass is run.
// Receiver stall: a two-entry output buffer absorbs one more transaction;
//   s_tready drops only when both entries are held.
module pulse_timing_record_replay_top #(
    parameter int ENTRY_COUNT   = 256,
    parameter int DURATION_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input transactions
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [0] pin_level, [7:1] zero
    input  logic [1:0]                        s_tuser,   // [1:0] op
    // Result transactions
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [0] drive_level, [1] recording,
                                                         // [2] playing, [11:3] entries_stored,
                                                         // [15:12] zero
    // Configuration writes
    input  logic                              cfg_we,
    input  logic [ptrr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ptrr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ptrr_pkg::*;

    localparam int ADDR_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int WORD_W = DURATION_BITS + 1;

    logic              accept;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_a_addr;
    logic [ADDR_W-1:0] rd_b_addr;
    logic [WORD_W-1:0] rd_a_data;
    logic [WORD_W-1:0] rd_b_data;
    ptrr_result_t      step_result;
    ptrr_result_t      out_result;

    assign accept = s_tvalid && s_tready;

    // Pulse store: each entry holds {level, duration}, duration zero meaning a full wrap
    ptrr_store #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .WORD_W      (WORD_W),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    // Step logic: advance recording or playback once per accepted transaction
    ptrr_ctrl #(
        .ENTRY_COUNT   (ENTRY_COUNT),
        .DURATION_BITS (DURATION_BITS),
        .ADDR_W        (ADDR_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .op        (s_tuser),
        .pin_level (s_tdata[0]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .result    (step_result)
    );

    // Hold results while the receiver stalls
    ptrr_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (step_result),
        .in_ready  (s_tready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_result)
    );

    assign m_tdata = {4'b0000, out_result.entries_stored, out_result.playing,
                      out_result.recording, out_result.drive_level};

endmodule

// File: rtl/core/ptrr_store.sv
// Pulse store: one write port, two registered read ports, write forwarding.
// Depends on nothing but its parameters.
module ptrr_store #(
    parameter int ENTRY_COUNT = 256,
    parameter int WORD_W      = 17,
    parameter int ADDR_W      = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_a_addr,
    input  logic [ADDR_W-1:0] rd_b_addr,
    output logic [WORD_W-1:0] rd_a_data,
    output logic [WORD_W-1:0] rd_b_data
);

    logic [WORD_W-1:0] mem [ENTRY_COUNT];
    logic [WORD_W-1:0] q_a_reg;
    logic [WORD_W-1:0] q_b_reg;
    logic [WORD_W-1:0] wd_reg;
    logic              fwd_a_reg;
    logic              fwd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        q_a_reg <= mem[rd_a_addr];
        q_b_reg <= mem[rd_b_addr];
        wd_reg  <= wr_data;
    end

    // The array returns old data on a same-address write; forward the new word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end else begin
            fwd_a_reg <= wr_en && (wr_addr == rd_a_addr);
            fwd_b_reg <= wr_en && (wr_addr == rd_b_addr);
        end
    end

    assign rd_a_data = fwd_a_reg ? wd_reg : q_a_reg;
    assign rd_b_data = fwd_b_reg ? wd_reg : q_b_reg;

endmodule

// File: rtl/core/ptrr_ctrl.sv
// Record/replay control: run state, configuration registers, store access.
// Depends on ptrr_pkg; drives the ptrr_store ports and produces one result per item.
module ptrr_ctrl #(
    parameter int ENTRY_COUNT   = 256,
    parameter int DURATION_BITS = 16,
    parameter int ADDR_W        = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic [1:0]                        op,
    input  logic                              pin_level,
    input  logic                              cfg_we,
    input  logic [ptrr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ptrr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [DURATION_BITS:0]            rd_a_data,
    input  logic [DURATION_BITS:0]            rd_b_data,
    output logic [ADDR_W-1:0]                 rd_a_addr,
    output logic [ADDR_W-1:0]                 rd_b_addr,
    output logic                              wr_en,
    output logic [ADDR_W-1:0]                 wr_addr,
    output logic [DURATION_BITS:0]            wr_data,
    output ptrr_pkg::ptrr_result_t            result
);
    import ptrr_pkg::*;

    localparam int DB     = DURATION_BITS;
    localparam int IDX_MIN = $clog2(ENTRY_COUNT + 1);
    localparam int IDX_W  = (IDX_MIN > 9) ? IDX_MIN : 9;

    logic [1:0]              mode_reg,   mode_next;
    logic [DB-1:0]           tick_reg,   tick_next;
    logic [IDX_W-1:0]        index_reg,  index_next;
    logic                    level_reg,  level_next;
    logic [REPEAT_W-1:0]     passes_reg, passes_next;
    logic [STORED_W-1:0]     stored_reg, stored_next;
    logic [WIN_START_W-1:0]  ws_reg,     ws_next;
    logic [WIN_LENGTH_W-1:0] wl_reg,     wl_next;
    logic [REPEAT_W-1:0]     rc_reg,     rc_next;

    logic                    lvl;
    logic [WIN_LENGTH_W-1:0] len_eff;
    logic [WIN_LENGTH_W-1:0] len_eff_next;
    logic [IDX_W-1:0]        index_inc;
    logic [REPEAT_W-1:0]     passes_inc;
    logic [IDX_W-1:0]        pf_inc;
    logic [7:0]              pf_off;

    // (base + offset) mod ENTRY_COUNT for a 9-bit sum: restoring subtract of N<<k
    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [8:0] s);
        logic [8:0] r;
        r = s;
        for (int k = 8; k >= 0; k--) begin
            if ((ENTRY_COUNT << k) <= 511) begin
                if (r >= 9'(ENTRY_COUNT << k)) begin
                    r = r - 9'(ENTRY_COUNT << k);
                end
            end
        end
        return ADDR_W'(r);
    endfunction

    assign lvl        = ~pin_level;
    assign len_eff    = (wl_reg == '0) ? WIN_LENGTH_W'(1) : wl_reg;
    assign index_inc  = index_reg + IDX_W'(1);
    assign passes_inc = passes_reg + REPEAT_W'(1);

    // Configuration
    always_comb begin
        ws_next = ws_reg;
        wl_next = wl_reg;
        rc_next = rc_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_WINDOW_START:  ws_next = cfg_wdata[WIN_START_W-1:0];
                REG_WINDOW_LENGTH: wl_next = cfg_wdata[WIN_LENGTH_W-1:0];
                REG_REPEAT_COUNT:  rc_next = cfg_wdata[REPEAT_W-1:0];
                default: ;
            endcase
        end
    end

    // Item step
    always_comb begin
        mode_next   = mode_reg;
        tick_next   = tick_reg;
        index_next  = index_reg;
        level_next  = level_reg;
        passes_next = passes_reg;
        stored_next = stored_reg;
        wr_en       = 1'b0;
        wr_addr     = index_reg[ADDR_W-1:0];
        wr_data     = {level_reg, tick_reg};
        if (accept) begin
            case (op)
                OP_REC: begin
                    mode_next   = MODE_REC;
                    index_next  = '0;
                    stored_next = '0;
                    passes_next = '0;
                    level_next  = lvl;
                    tick_next   = DB'(1);
                end
                OP_PLAY: begin
                    index_next  = '0;
                    passes_next = '0;
                    if (rc_reg == '0) begin
                        mode_next  = MODE_IDLE;
                        level_next = 1'b0;
                        tick_next  = '0;
                    end else begin
                        mode_next  = MODE_PLAY;
                        level_next = rd_b_data[DB];
                        tick_next  = rd_b_data[DB-1:0] - DB'(1);
                    end
                end
                default: begin
                    if (mode_reg == MODE_REC) begin
                        if (lvl != level_reg) begin
                            // Close the run; skip the empty run after a wrap entry
                            if (tick_reg != '0) begin
                                wr_en       = 1'b1;
                                wr_data     = {level_reg, tick_reg};
                                index_next  = index_inc;
                                stored_next = index_inc[STORED_W-1:0];
                                if (index_inc == IDX_W'(ENTRY_COUNT)) begin
                                    mode_next = MODE_IDLE;
                                end
                            end
                            level_next = lvl;
                            tick_next  = DB'(1);
                        end else if (tick_reg == '1) begin
                            // Full-length run: store a wrap entry, keep counting
                            wr_en       = 1'b1;
                            wr_data     = {level_reg, {DB{1'b0}}};
                            index_next  = index_inc;
                            stored_next = index_inc[STORED_W-1:0];
                            if (index_inc == IDX_W'(ENTRY_COUNT)) begin
                                mode_next = MODE_IDLE;
                            end
                            tick_next = '0;
                        end else begin
                            tick_next = tick_reg + DB'(1);
                        end
                    end else if (mode_reg == MODE_PLAY) begin
                        if (tick_reg != '0) begin
                            tick_next = tick_reg - DB'(1);
                        end else if (index_inc >= IDX_W'(len_eff)) begin
                            index_next  = '0;
                            passes_next = passes_inc;
                            if (passes_inc >= rc_reg) begin
                                mode_next  = MODE_IDLE;
                                level_next = 1'b0;
                            end else begin
                                level_next = rd_a_data[DB];
                                tick_next  = rd_a_data[DB-1:0] - DB'(1);
                            end
                        end else begin
                            index_next = index_inc;
                            level_next = rd_a_data[DB];
                            tick_next  = rd_a_data[DB-1:0] - DB'(1);
                        end
                    end
                end
            endcase
        end
    end

    // Prefetch from next state: port A holds the entry the next load would take,
    // port B the first window entry for a playback start.
    assign len_eff_next = (wl_next == '0) ? WIN_LENGTH_W'(1) : wl_next;
    assign pf_inc       = index_next + IDX_W'(1);
    assign pf_off       = (pf_inc >= IDX_W'(len_eff_next)) ? 8'd0 : pf_inc[7:0];
    assign rd_a_addr    = wrap_addr({1'b0, ws_next} + {1'b0, pf_off});
    assign rd_b_addr    = wrap_addr({1'b0, ws_next});

    always_comb begin
        result                = '0;
        result.recording      = (mode_next == MODE_REC);
        result.playing        = (mode_next == MODE_PLAY);
        result.entries_stored = stored_next;
        if (mode_next == MODE_REC) begin
            result.drive_level = lvl;
        end else if (mode_next == MODE_PLAY) begin
            result.drive_level = level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            tick_reg   <= '0;
            index_reg  <= '0;
            level_reg  <= 1'b0;
            passes_reg <= '0;
            stored_reg <= '0;
            ws_reg     <= '0;
            wl_reg     <= WIN_LENGTH_W'(1);
            rc_reg     <= REPEAT_W'(1);
        end else begin
            mode_reg   <= mode_next;
            tick_reg   <= tick_next;
            index_reg  <= index_next;
            level_reg  <= level_next;
            passes_reg <= passes_next;
            stored_reg <= stored_next;
            ws_reg     <= ws_next;
            wl_reg     <= wl_next;
            rc_reg     <= rc_next;
        end
    end

    a_write_only_recording: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (mode_reg == MODE_REC))
        else $error("store written outside recording");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_REC) |-> (index_reg < IDX_W'(ENTRY_COUNT)))
        else $error("record slot past store end");

    a_rec_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (op == OP_REC)) |=> (mode_reg == MODE_REC))
        else $error("record start did not enter recording");

endmodule

// File: rtl/core/ptrr_out_buf.sv
// Two-entry result buffer between the step logic and the master channel.
// Depends on ptrr_pkg for the result type.
module ptrr_out_buf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ptrr_pkg::ptrr_result_t push_data,
    output logic                   in_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ptrr_pkg::ptrr_result_t m_data
);
    import ptrr_pkg::*;

    ptrr_result_t head_reg,       head_next;
    ptrr_result_t skid_reg,       skid_next;
    logic         head_valid_reg, head_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    logic         pop;

    assign in_ready = !skid_valid_reg;
    assign pop      = head_valid_reg && m_ready;

    always_comb begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!head_valid_reg || pop) begin
            // Refill the head from the skid stage first
            if (skid_valid_reg) begin
                head_next       = skid_reg;
                head_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                head_next       = push_data;
                head_valid_next = push;
            end
        end else if (push) begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign m_valid = head_valid_reg;
    assign m_data  = head_reg;

    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> head_valid_reg)
        else $error("pushed result not presented");

    a_skid_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry without head entry");

endmodule

// File: tb/pulse_timing_record_replay_top_test.sv
// Self-checking testbench for pulse_timing_record_replay_top: idle defaults, record,
// store-full, window and repeat settings, receiver stalls and random record/replay traffic.
// Depends on ptrr_pkg and the RTL of the block; reads no files.
module pulse_timing_record_replay_top_test;
    import ptrr_pkg::*;

    // Op code 3 is unused by the block and decodes as a plain tick
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STORE_DEPTH  = 256;
    localparam int STALL_CYCLES = 300;
    localparam int RANDOM_ITEMS = 600;
    localparam int QUIET_ITEMS  = 150;
    localparam int DRAIN_LIMIT  = 10000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;    // [0] pin_level, [7:1] zero
    logic [1:0]             s_tuser   = '0;    // [1:0] op
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [15:0]            m_tdata;           // [0] drive_level, [1] recording, [2] playing,
                                               // [11:3] entries_stored, [15:12] zero
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    pulse_timing_record_replay_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Recorder/replayer predictor: own copy of state and registers,
    // initialized to the reset values of the block.
    // ------------------------------------------------------------------
    logic [16:0]          pulse_mem [0:STORE_DEPTH-1];   // {level, duration}
    bit                   mem_written [0:STORE_DEPTH-1];
    logic [16:0]          run_ticks  = '0;
    logic [8:0]           slot       = '0;
    bit                   level      = 1'b0;
    logic [15:0]          passes     = '0;
    logic [1:0]           mode       = MODE_IDLE;
    logic [8:0]           stored_cnt = '0;
    logic [7:0]           win_start  = 8'd0;
    logic [8:0]           win_len    = 9'd1;
    logic [15:0]          repeats    = 16'd1;

    // Status words expected on the master side, oldest first
    ptrr_result_t         status_due [$];

    int                   errors     = 0;
    int                   items_sent = 0;
    bit                   sender_gaps = 1'b1;
    bit                   ready_gaps  = 1'b1;
    bit                   stall_request = 1'b0;
    int                   stall_left = 0;
    int                   ready_hold = 0;

    // True when every entry the current window can address has been recorded
    function automatic bit window_ready();
        int         n;
        logic [7:0] addr;
        n = (win_len == 0) ? 1 : ((win_len > STORE_DEPTH) ? STORE_DEPTH : int'(win_len));
        for (int k = 0; k < n; k++) begin
            addr = win_start + k[7:0];
            if (!mem_written[addr])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [1:0] tick_op();
        return ($urandom_range(0, 9) == 0) ? OP_UNUSED : OP_TICK;
    endfunction

    // Fetch the window entry at the current offset; the address wraps past the store end
    task automatic load_slot();
        logic [7:0]  addr;
        logic [16:0] word;
        addr      = win_start + slot[7:0];
        word      = pulse_mem[addr];
        level     = word[16];
        run_ticks = {1'b0, word[15:0] - 16'd1};
    endtask

    task automatic save_run(input logic [15:0] dur, input bit lv);
        if (slot >= STORE_DEPTH) begin
            mode = MODE_IDLE;
            return;
        end
        pulse_mem[slot[7:0]]   = {lv, dur};
        mem_written[slot[7:0]] = 1'b1;
        slot       = slot + 9'd1;
        stored_cnt = slot;
        if (slot >= STORE_DEPTH)
            mode = MODE_IDLE;
    endtask

    // Advance the predictor by one accepted transaction and queue the status it yields
    task automatic predict_status(input logic [1:0] op, input bit pin);
        bit           lv;
        bit           done;
        logic [8:0]   len;
        ptrr_result_t res;
        lv = ~pin;
        if (op == OP_REC) begin
            mode       = MODE_REC;
            slot       = '0;
            stored_cnt = '0;
            passes     = '0;
            level      = lv;
            run_ticks  = 17'd1;
        end else if (op == OP_PLAY) begin
            slot   = '0;
            passes = '0;
            if (repeats == 0) begin
                mode      = MODE_IDLE;
                level     = 1'b0;
                run_ticks = '0;
            end else begin
                mode = MODE_PLAY;
                load_slot();
            end
        end else if (mode == MODE_REC) begin
            if (lv != level) begin
                // a change right after a wrap leaves an empty run: store nothing
                if (run_ticks != 0)
                    save_run(run_ticks[15:0], level);
                level     = lv;
                run_ticks = 17'd1;
            end else begin
                run_ticks = run_ticks + 17'd1;
                if (run_ticks > 17'h0FFFF) begin
                    save_run(16'd0, level);
                    run_ticks = '0;
                end
            end
        end else if (mode == MODE_PLAY) begin
            len = (win_len == 0) ? 9'd1 : win_len;
            if (run_ticks != 0) begin
                run_ticks = run_ticks - 17'd1;
            end else begin
                done = 1'b0;
                slot = slot + 9'd1;
                if (slot >= len) begin
                    slot   = '0;
                    passes = passes + 16'd1;
                    done   = (passes >= repeats);
                end
                if (done) begin
                    mode  = MODE_IDLE;
                    level = 1'b0;
                end else begin
                    load_slot();
                end
            end
        end
        res.drive_level    = (mode == MODE_REC) ? lv : ((mode == MODE_PLAY) ? level : 1'b0);
        res.recording      = (mode == MODE_REC);
        res.playing        = (mode == MODE_PLAY);
        res.entries_stored = stored_cnt;
        status_due.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one transaction, hold it until accepted, then predict its status.
    // tvalid stays high afterwards so back-to-back items need no extra step.
    task automatic send_item(input logic [1:0] op, input bit pin);
        int gap;
        if (sender_gaps && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, pin};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_status(op, pin);
        items_sent++;
    endtask

    // Drop tvalid and wait until every expected status has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (status_due.size() != 0) @(posedge aclk);
    endtask

    // Write one register; the block must be idle and drained
    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_WINDOW_START:  win_start = value[WIN_START_W-1:0];
            REG_WINDOW_LENGTH: win_len   = value[WIN_LENGTH_W-1:0];
            REG_REPEAT_COUNT:  repeats   = value[REPEAT_W-1:0];
            default: ;
        endcase
    endtask

    // Start a recording and feed n runs of alternating level, each 1 to max_len ticks
    task automatic record_runs(input int n, input int max_len);
        bit pin;
        int len;
        pin = 1'($urandom_range(0, 1));
        for (int r = 0; r < n; r++) begin
            len = $urandom_range(1, max_len);
            for (int j = 0; j < len; j++)
                send_item((r == 0 && j == 0) ? OP_REC : tick_op(), pin);
            pin = ~pin;
        end
    endtask

    // Bring the block back to idle: cut a recording short with a playback, then tick
    task automatic run_to_idle();
        while (mode != MODE_IDLE)
            send_item((mode == MODE_REC) ? OP_PLAY : tick_op(), 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_idle_defaults();
        // ticks and the unused op while idle change nothing
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b1);
        send_item(OP_UNUSED, 1'b0);
        send_item(OP_UNUSED, 1'b1);
        drain();
        // zero repeats: playback ends at once, nothing is read from the store
        set_reg(REG_REPEAT_COUNT, 16'd0);
        send_item(OP_PLAY, 1'b0);
        send_item(OP_PLAY, 1'b1);
        send_item(OP_TICK, 1'b0);
        drain();
        set_reg(REG_REPEAT_COUNT, 16'd1);
    endtask

    task automatic test_store_full();
        // restart while recording, then fill every slot with short runs
        send_item(OP_REC, 1'b1);
        repeat (5) send_item(OP_TICK, 1'b0);
        record_runs(262, 3);
        repeat (3) send_item(OP_TICK, 1'b1);
    endtask

    task automatic test_window_settings();
        int k;
        drain();
        // whole store from the last slot: the window wraps past the store end
        set_reg(REG_WINDOW_START, 16'd255);
        set_reg(REG_WINDOW_LENGTH, 16'd256);
        set_reg(REG_REPEAT_COUNT, 16'd1);
        send_item(OP_PLAY, 1'b0);
        run_to_idle();
        drain();
        // zero length replays as length one
        set_reg(REG_WINDOW_START, 16'd0);
        set_reg(REG_WINDOW_LENGTH, 16'd0);
        send_item(OP_PLAY, 1'b1);
        run_to_idle();
        drain();
        // many passes, on a one-tick entry so the run stays short
        k = 0;
        for (int i = STORE_DEPTH - 1; i >= 0; i--)
            if (pulse_mem[i][15:0] == 16'd1)
                k = i;
        set_reg(REG_WINDOW_START, k[15:0]);
        set_reg(REG_WINDOW_LENGTH, 16'd1);
        set_reg(REG_REPEAT_COUNT, 16'd200);
        send_item(OP_PLAY, 1'b0);
        run_to_idle();
        drain();
        // new starts while busy abandon the current activity
        set_reg(REG_WINDOW_START, 16'd10);
        set_reg(REG_WINDOW_LENGTH, 16'd4);
        set_reg(REG_REPEAT_COUNT, 16'd3);
        send_item(OP_PLAY, 1'b0);
        repeat (5) send_item(OP_TICK, 1'b1);
        send_item(OP_PLAY, 1'b1);
        repeat (3) send_item(OP_TICK, 1'b0);
        send_item(OP_REC, 1'b0);
        repeat (4) send_item(OP_TICK, 1'b1);
        send_item(OP_PLAY, 1'b0);
        run_to_idle();
    endtask

    task automatic test_receiver_stall();
        drain();
        set_reg(REG_WINDOW_START, 16'd0);
        set_reg(REG_WINDOW_LENGTH, 16'd4);
        set_reg(REG_REPEAT_COUNT, 16'd2);
        // receiver holds off for a long stretch; keep offering so the input stalls
        stall_request = 1'b1;
        record_runs(12, 4);
        send_item(OP_PLAY, 1'b1);
        run_to_idle();
    endtask

    task automatic test_random_traffic();
        int         first;
        int         kind;
        int         pick;
        logic [1:0] op;
        logic [8:0] len;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            if (items_sent - first > RANDOM_ITEMS - QUIET_ITEMS) begin
                sender_gaps = 1'b0;
                ready_gaps  = 1'b0;
            end else begin
                sender_gaps = ($urandom_range(0, 3) != 0);
                ready_gaps  = ($urandom_range(0, 3) != 0);
            end
            run_to_idle();
            drain();
            if ($urandom_range(0, 2) != 0) begin
                pick = $urandom_range(0, 9);
                if (pick < 8)
                    len = 9'($urandom_range(1, 8));
                else if (pick == 8)
                    len = 9'd0;
                else
                    len = 9'($urandom_range(9, 256));
                set_reg(REG_WINDOW_START, 16'($urandom_range(0, 255)));
                set_reg(REG_WINDOW_LENGTH, {7'b0, len});
                set_reg(REG_REPEAT_COUNT,
                        16'((len > 8) ? $urandom_range(0, 1) : $urandom_range(0, 4)));
            end
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                // well-formed: record some runs, replay, sometimes cut short
                record_runs($urandom_range(1, 20), ($urandom_range(0, 4) == 0) ? 40 : 8);
                if ($urandom_range(0, 3) != 0) begin
                    send_item(OP_PLAY, 1'($urandom_range(0, 1)));
                    if ($urandom_range(0, 4) == 0) begin
                        repeat ($urandom_range(1, 20))
                            send_item(tick_op(), 1'($urandom_range(0, 1)));
                        send_item($urandom_range(0, 1) ? OP_REC : OP_PLAY,
                                  1'($urandom_range(0, 1)));
                    end
                end
            end else begin
                // noise: any op with any pin, never replaying unrecorded entries
                repeat ($urandom_range(5, 30)) begin
                    op = 2'($urandom_range(0, 3));
                    if (op == OP_PLAY && repeats != 0 && !window_ready())
                        op = OP_TICK;
                    send_item(op, 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: check each accepted transaction against the oldest
    // expectation, then decide tready for the next edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        ptrr_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (status_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual tdata %h", $time, m_tdata);
            end else begin
                want = status_due.pop_front();
                if (m_tdata !== {4'b0000, want}) begin
                    errors++;
                    $display("%0t: mismatch, expected drive %0b rec %0b play %0b stored %0d pad 0",
                             $time, want.drive_level, want.recording, want.playing,
                             want.entries_stored);
                    $display("%0t:           actual   drive %0b rec %0b play %0b stored %0d pad %h",
                             $time, m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[11:3],
                             m_tdata[15:12]);
                end
            end
        end
        if (stall_request) begin
            stall_left    = STALL_CYCLES;
            stall_request = 1'b0;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (ready_hold != 0) begin
            ready_hold--;
            m_tready <= 1'b0;
        end else if (ready_gaps && $urandom_range(0, 7) == 0) begin
            // start a burst of low tready here; ready_hold sets how long it lasts
            ready_hold = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        int waited;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_defaults();
        test_store_full();
        test_window_settings();
        test_receiver_stall();
        test_random_traffic();
        s_tvalid <= 1'b0;
        waited = 0;
        while (status_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
        if (status_due.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, status_due.size());
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop in case the block hangs
    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
